FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on i_clk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define HSVRGB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define HSVRGB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hdl/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// types, constants and fixed-point helpers for the hsv to rgb converter
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    localparam int NumStages   = 8;
    localparam int PctFull     = 100;
    localparam int SectorDeg   = 60;
    localparam int HueTurn     = 360;
    localparam int ChanMax     = 255;
    localparam int Recip100    = 5243;
    localparam int Recip100Sh  = 19;
    localparam int Recip3      = 683;
    localparam int Recip3Sh    = 11;

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } t_sector;

    // exact floor(x / 100) for x below 25600
    function automatic logic [7:0] div100(input logic [14:0] x);
        logic [27:0] m;
        m = 28'(x) * 28'(Recip100);
        return m[Recip100Sh+7:Recip100Sh];
    endfunction

    // exact floor(x / 3) for x below 384
    function automatic logic [6:0] div3(input logic [8:0] x);
        logic [19:0] m;
        m = 20'(x) * 20'(Recip3);
        return m[Recip3Sh+6:Recip3Sh];
    endfunction

endpackage

FILE: hdl/hsvrgb_dpath.sv
// ----------------------------------------------------------------------------
// hsvrgb_dpath
// eight-stage datapath: sector split, p/q/t products and 8-bit scaling
// ----------------------------------------------------------------------------
module hsvrgb_dpath
    import hsvrgb_pkg::*;
(
    input  logic                 i_clk,
    input  logic [NumStages-1:0] i_en,
    input  logic [8:0]           i_hue,
    input  logic [6:0]           i_saturation,
    input  logic [6:0]           i_brightness,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue
);

    // stage 0
    logic [8:0]  n_h;
    logic [8:0]  n_base;
    t_sector     n_s0_sector;
    logic [6:0]  n_s0_s;
    logic [6:0]  n_s0_v;
    t_sector     r_s0_sector;
    logic [5:0]  r_s0_rem;
    logic [6:0]  r_s0_s;
    logic [6:0]  r_s0_v;
    logic        r_s0_grey;
    // stage 1
    t_sector     r_s1_sector;
    logic [6:0]  r_s1_frac;
    logic [6:0]  r_s1_s;
    logic [6:0]  r_s1_v;
    logic        r_s1_grey;
    // stage 2
    t_sector     r_s2_sector;
    logic [13:0] r_s2_ap;
    logic [13:0] r_s2_aq;
    logic [13:0] r_s2_at;
    logic [6:0]  r_s2_v;
    logic        r_s2_grey;
    // stage 3
    t_sector     r_s3_sector;
    logic [6:0]  r_s3_p;
    logic [6:0]  r_s3_kq;
    logic [6:0]  r_s3_kt;
    logic [6:0]  r_s3_v;
    logic        r_s3_grey;
    // stage 4
    t_sector     r_s4_sector;
    logic [6:0]  r_s4_p;
    logic [13:0] r_s4_bq;
    logic [13:0] r_s4_bt;
    logic [6:0]  r_s4_v;
    logic        r_s4_grey;
    // stage 5
    t_sector     r_s5_sector;
    logic [6:0]  r_s5_p;
    logic [6:0]  r_s5_q;
    logic [6:0]  r_s5_t;
    logic [6:0]  r_s5_v;
    logic        r_s5_grey;
    // stage 6
    logic [6:0]  n_r;
    logic [6:0]  n_g;
    logic [6:0]  n_b;
    logic [14:0] r_s6_r;
    logic [14:0] r_s6_g;
    logic [14:0] r_s6_b;
    // stage 7
    logic [7:0]  r_s7_r;
    logic [7:0]  r_s7_g;
    logic [7:0]  r_s7_b;

    always_comb begin
        n_h    = (i_hue >= 9'(HueTurn)) ? 9'd0 : i_hue;
        n_s0_s = (i_saturation > 7'(PctFull)) ? 7'(PctFull) : i_saturation;
        n_s0_v = (i_brightness > 7'(PctFull)) ? 7'(PctFull) : i_brightness;
        priority if (n_h >= 9'(SectorDeg * 5)) begin
            n_s0_sector = SEC_MR;
            n_base      = 9'(SectorDeg * 5);
        end else if (n_h >= 9'(SectorDeg * 4)) begin
            n_s0_sector = SEC_BM;
            n_base      = 9'(SectorDeg * 4);
        end else if (n_h >= 9'(SectorDeg * 3)) begin
            n_s0_sector = SEC_CB;
            n_base      = 9'(SectorDeg * 3);
        end else if (n_h >= 9'(SectorDeg * 2)) begin
            n_s0_sector = SEC_GC;
            n_base      = 9'(SectorDeg * 2);
        end else if (n_h >= 9'(SectorDeg)) begin
            n_s0_sector = SEC_YG;
            n_base      = 9'(SectorDeg);
        end else begin
            n_s0_sector = SEC_RY;
            n_base      = 9'd0;
        end
    end

    always_comb begin
        if (r_s5_grey) begin
            n_r = r_s5_v;
            n_g = r_s5_v;
            n_b = r_s5_v;
        end else begin
            unique case (r_s5_sector)
                SEC_RY: begin
                    n_r = r_s5_v; n_g = r_s5_t; n_b = r_s5_p;
                end
                SEC_YG: begin
                    n_r = r_s5_q; n_g = r_s5_v; n_b = r_s5_p;
                end
                SEC_GC: begin
                    n_r = r_s5_p; n_g = r_s5_v; n_b = r_s5_t;
                end
                SEC_CB: begin
                    n_r = r_s5_p; n_g = r_s5_q; n_b = r_s5_v;
                end
                SEC_BM: begin
                    n_r = r_s5_t; n_g = r_s5_p; n_b = r_s5_v;
                end
                default: begin
                    n_r = r_s5_v; n_g = r_s5_p; n_b = r_s5_q;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s0_sector <= n_s0_sector;
            r_s0_rem    <= 6'(n_h - n_base);
            r_s0_s      <= n_s0_s;
            r_s0_v      <= n_s0_v;
            r_s0_grey   <= (n_s0_s == 7'd0);
        end
        if (i_en[1]) begin
            r_s1_sector <= r_s0_sector;
            r_s1_frac   <= div3(9'(r_s0_rem) * 9'd5);
            r_s1_s      <= r_s0_s;
            r_s1_v      <= r_s0_v;
            r_s1_grey   <= r_s0_grey;
        end
        if (i_en[2]) begin
            r_s2_sector <= r_s1_sector;
            r_s2_ap     <= 14'(r_s1_v) * 14'(7'(PctFull) - r_s1_s);
            r_s2_aq     <= 14'(r_s1_s) * 14'(r_s1_frac);
            r_s2_at     <= 14'(r_s1_s) * 14'(7'(PctFull) - r_s1_frac);
            r_s2_v      <= r_s1_v;
            r_s2_grey   <= r_s1_grey;
        end
        if (i_en[3]) begin
            r_s3_sector <= r_s2_sector;
            r_s3_p      <= 7'(div100(15'(r_s2_ap)));
            r_s3_kq     <= 7'(PctFull) - 7'(div100(15'(r_s2_aq)));
            r_s3_kt     <= 7'(PctFull) - 7'(div100(15'(r_s2_at)));
            r_s3_v      <= r_s2_v;
            r_s3_grey   <= r_s2_grey;
        end
        if (i_en[4]) begin
            r_s4_sector <= r_s3_sector;
            r_s4_p      <= r_s3_p;
            r_s4_bq     <= 14'(r_s3_v) * 14'(r_s3_kq);
            r_s4_bt     <= 14'(r_s3_v) * 14'(r_s3_kt);
            r_s4_v      <= r_s3_v;
            r_s4_grey   <= r_s3_grey;
        end
        if (i_en[5]) begin
            r_s5_sector <= r_s4_sector;
            r_s5_p      <= r_s4_p;
            r_s5_q      <= 7'(div100(15'(r_s4_bq)));
            r_s5_t      <= 7'(div100(15'(r_s4_bt)));
            r_s5_v      <= r_s4_v;
            r_s5_grey   <= r_s4_grey;
        end
        if (i_en[6]) begin
            r_s6_r <= 15'(n_r) * 15'(ChanMax);
            r_s6_g <= 15'(n_g) * 15'(ChanMax);
            r_s6_b <= 15'(n_b) * 15'(ChanMax);
        end
        if (i_en[7]) begin
            r_s7_r <= div100(r_s6_r);
            r_s7_g <= div100(r_s6_g);
            r_s7_b <= div100(r_s6_b);
        end
    end

    assign o_red   = r_s7_r;
    assign o_green = r_s7_g;
    assign o_blue  = r_s7_b;

endmodule

FILE: hdl/hsv_to_rgb_percent_fixed.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_percent_fixed
// hsv pixel (degrees, percent, percent) to 8-bit rgb, integer arithmetic
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  pixel in   in       i_valid / o_ready   i_hue, i_saturation, i_brightness
//  pixel out  out      o_valid / i_ready   o_red, o_green, o_blue
//
//  one beat per cycle unless the output is held; each beat passes the register
//  stages of the datapath (sector split, two product/divide pairs, channel scaling)
//  synchronous reset clears the stage valid bits only
//  a stall holds full stages; empty stages still fill, so bubbles close up
//  o_ready falls only when every stage is full and the output is held
// ----------------------------------------------------------------------------
module hsv_to_rgb_percent_fixed
    import hsvrgb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [8:0] i_hue,
    input  logic [6:0] i_saturation,
    input  logic [6:0] i_brightness,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);

    logic [NumStages-1:0] r_valid;
    logic [NumStages-1:0] n_valid;
    logic [NumStages-1:0] stage_en;
    logic [NumStages-1:0] valid_in;

    always_comb begin
        for (int k = NumStages - 1; k >= 0; k--) begin
            if (k == NumStages - 1) begin
                stage_en[k] = !r_valid[k] || i_ready;
            end else begin
                stage_en[k] = !r_valid[k] || stage_en[k+1];
            end
        end
        valid_in = {r_valid[NumStages-2:0], i_valid};
        for (int k = 0; k < NumStages; k++) begin
            n_valid[k] = stage_en[k] ? valid_in[k] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    hsvrgb_dpath u_dpath (
        .i_clk        (i_clk),
        .i_en         (stage_en),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    assign o_ready = stage_en[0];
    assign o_valid = r_valid[NumStages-1];

endmodule

FILE: hdl/hsvrgb_chk.sv
// ----------------------------------------------------------------------------
// hsvrgb_chk
// port-level checks on the converter, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsvrgb_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue
);

    logic [23:0] rgb;

    assign rgb = {o_red, o_green, o_blue};

    // held result beat stays offered
    `HSVRGB_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid, "result beat dropped while stalled")

    // held result beat keeps its pixel
    `HSVRGB_ASSERT(a_out_stable, o_valid && !i_ready |=> $stable(rgb), "pixel changed in stall")

    // input side only backs up when the output is held
    `HSVRGB_ASSERT(a_stall_cause, !o_ready |-> o_valid && !i_ready, "input stalled with room left")

    // pipeline empty right after reset
    `HSVRGB_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid, "beat right after reset")

endmodule

bind hsv_to_rgb_percent_fixed hsvrgb_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_red   (o_red),
    .o_green (o_green),
    .o_blue  (o_blue)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for hsv_to_rgb_percent_fixed
// drives hsv pixels through the valid/ready input, predicts each rgb pixel
// with an integer percent model and checks every output beat in order; both
// sides idle at random, and the output is once held off until the input stalls
// ----------------------------------------------------------------------------
module testbench;
    import hsvrgb_pkg::*;

    localparam int IdleLimit  = 2000;
    localparam int HoldCycles = 300;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [8:0] i_hue;
    logic [6:0] i_saturation;
    logic [6:0] i_brightness;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_red;
    logic [7:0] o_green;
    logic [7:0] o_blue;

    t_rgb        rgb_expected[$];
    int unsigned pixels_sent;
    int unsigned pixels_done;
    int unsigned errors;
    int unsigned idle_cycles;
    bit          steady;
    int unsigned sink_hold;
    bit          sink_holding;

    hsv_to_rgb_percent_fixed dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_rgb hsv_to_rgb(input logic [8:0] hue, input logic [6:0] sat,
                                        input logic [6:0] bri);
        int unsigned s, v, scaled, frac, p, q, t, r, g, b;
        t_sector     sector;
        t_rgb        px;
        s = (sat > PctFull) ? PctFull : sat;
        v = (bri > PctFull) ? PctFull : bri;
        if (s == 0) begin
            r = v;
            g = v;
            b = v;
        end else begin
            scaled = (hue >= HueTurn) ? 0 : (int'(hue) * PctFull) / SectorDeg;
            sector = t_sector'(3'(scaled / PctFull));
            frac   = scaled % PctFull;
            p = (v * (PctFull - s)) / PctFull;
            q = (v * (PctFull - (s * frac) / PctFull)) / PctFull;
            t = (v * (PctFull - (s * (PctFull - frac)) / PctFull)) / PctFull;
            case (sector)
                SEC_RY: begin r = v; g = t; b = p; end
                SEC_YG: begin r = q; g = v; b = p; end
                SEC_GC: begin r = p; g = v; b = t; end
                SEC_CB: begin r = p; g = q; b = v; end
                SEC_BM: begin r = t; g = p; b = v; end
                default: begin r = v; g = p; b = q; end
            endcase
        end
        px.red   = 8'((r * ChanMax) / PctFull);
        px.green = 8'((g * ChanMax) / PctFull);
        px.blue  = 8'((b * ChanMax) / PctFull);
        return px;
    endfunction

    // mostly short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [6:0] rand_percent();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 7'd0;
        if (r == 1) return 7'($urandom_range(100, 127));
        if (r == 2) return 7'd1;
        return 7'($urandom_range(0, 127));
    endfunction

    task automatic report_channel(input string chan, input logic [7:0] want,
                                  input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, chan, want, got);
            errors++;
        end
    endtask

    // input beats queue predictions, output beats are checked against them
    always @(posedge i_clk) begin
        t_rgb want;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (i_valid && o_ready)
                rgb_expected.push_back(hsv_to_rgb(i_hue, i_saturation, i_brightness));
            if (o_valid && i_ready) begin
                if (rgb_expected.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %0d %0d %0d",
                             $time, o_red, o_green, o_blue);
                    errors++;
                end else begin
                    want = rgb_expected.pop_front();
                    report_channel("red", want.red, o_red);
                    report_channel("green", want.green, o_green);
                    report_channel("blue", want.blue, o_blue);
                end
                pixels_done++;
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IdleLimit) begin
                $display("%0t: no beat for %0d cycles", $time, IdleLimit);
                $display("CHECK FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // receiver: random stalls, a forced hold-off on request, none when steady
    initial begin : sink
        bit          level;
        int unsigned n;
        i_ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (sink_hold != 0) begin
                level        = 1'b0;
                n            = sink_hold;
                sink_hold    = 0;
                sink_holding = 1'b1;
            end else begin
                sink_holding = 1'b0;
                if (steady) begin
                    level = 1'b1;
                    n     = 1;
                end else begin
                    level = ($urandom_range(0, 3) != 0);
                    n     = pick_gap() + 1;
                end
            end
            i_ready <= level;
            repeat (n) @(posedge i_clk);
        end
    end

    task automatic send_pixel(input logic [8:0] hue, input logic [6:0] sat,
                              input logic [6:0] bri);
        int unsigned gap;
        gap = steady ? 0 : pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_brightness <= bri;
        do @(posedge i_clk); while (!o_ready);
        pixels_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pixels_done == pixels_sent);
    endtask

    // every sector edge, out-of-range hue, clamped and zero percentages
    task automatic test_corners();
        logic [8:0] hues[21];
        logic [6:0] sats[6];
        logic [6:0] bris[5];
        hues = '{0, 30, 59, 60, 90, 119, 120, 150, 179, 180, 210, 239, 240, 270,
                 299, 300, 330, 359, 360, 400, 511};
        sats = '{100, 1, 127, 0, 50, 101};
        bris = '{100, 0, 127, 1, 73};
        for (int i = 0; i < 21; i++)
            send_pixel(hues[i], sats[i % 6], bris[i % 5]);
        send_pixel(9'd359, 7'd127, 7'd127);
        send_pixel(9'd511, 7'd0, 7'd127);
        send_pixel(9'd0, 7'd127, 7'd0);
        drain();
    endtask

    // output held off long enough for the pipeline to fill and stall the input
    task automatic test_backpressure();
        steady    = 1'b1;
        sink_hold = HoldCycles;
        wait (sink_holding);
        for (int i = 0; i < 40; i++)
            send_pixel(9'($urandom_range(0, 511)), rand_percent(), rand_percent());
        drain();
        steady = 1'b0;
    endtask

    task automatic test_random();
        logic [8:0] hue;
        for (int blk = 0; blk < 17; blk++) begin
            steady = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 100; i++) begin
                hue = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(360, 511))
                                                 : 9'($urandom_range(0, 511));
                send_pixel(hue, rand_percent(), rand_percent());
            end
            if (blk % 4 == 3)
                drain();
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_hue        = '0;
        i_saturation = '0;
        i_brightness = '0;
        pixels_sent  = 0;
        pixels_done  = 0;
        errors       = 0;
        steady       = 1'b0;
        sink_hold    = 0;
        sink_holding = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corners();
        test_backpressure();
        test_random();

        drain();
        repeat (NumStages * 2) @(posedge i_clk);
        if (rgb_expected.size() != 0) begin
            $display("%0t: %0d pixels never came out", $time, rgb_expected.size());
            errors++;
        end
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/hsvrgb_pkg.sv
hdl/hsvrgb_dpath.sv
hdl/hsv_to_rgb_percent_fixed.sv
hdl/hsvrgb_chk.sv
test/testbench.sv
